// ===== hw/rtl/fta_pkg.sv =====
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types and constants for the fixed-timestep accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fta_pkg;

    // Field widths
    localparam int TIME_W    = 32;
    localparam int SPEED_W   = 24;
    localparam int SUB_W     = 8;
    localparam int ACC_W     = 40;
    localparam int ELAPSED_W = 32;
    localparam int MUL_W     = TIME_W + SPEED_W;

    // Register port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // Register reset values
    localparam logic [TIME_W-1:0]  STEP_RST   = 32'd1092;
    localparam logic [SPEED_W-1:0] SPEED_RST  = 24'd65536;
    localparam logic [SUB_W-1:0]   MAX_RST    = 8'd8;
    localparam logic [TIME_W-1:0]  THRESH_RST = 32'd16384;

    typedef enum logic [2:0] {
        MODE_UPDATE  = 3'd0,
        MODE_ENTER   = 3'd1,
        MODE_LEAVE   = 3'd2,
        MODE_START   = 3'd3,
        MODE_PAUSE   = 3'd4,
        MODE_RESET   = 3'd5,
        MODE_RESEED  = 3'd6,
        MODE_DYNAMIC = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_PAUSED  = 2'd0,
        ST_RUNNING = 2'd1,
        ST_BEHIND  = 2'd2,
        ST_FAULT   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_STEP   = 2'd0,
        REG_SPEED  = 2'd1,
        REG_MAX    = 2'd2,
        REG_THRESH = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MREQ,
        S_MCAP,
        S_AVAIL,
        S_TAKE,
        S_ADD,
        S_LOOP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]  step_length;
        logic [SPEED_W-1:0] speed;
        logic [SUB_W-1:0]   max_substeps;
        logic [TIME_W-1:0]  suspend_threshold;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        mode;
        logic [TIME_W-1:0] wall_duration;
        logic              dragging;
        logic              seed_valid;
        logic [SUB_W-1:0]  fail_at_step;
    } t_in_item;

    typedef struct packed {
        logic [SUB_W-1:0]     granted_steps;
        logic                 state_changed;
        logic                 behind;
        logic                 numeric_fault;
        logic [1:0]           status;
        logic                 command_ok;
        logic [ELAPSED_W-1:0] elapsed_steps;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hw/rtl/fta_if.sv =====
// ----------------------------------------------------------------------------
// fta_if
// Valid/ready channels carrying input events and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fta_in_if import fta_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fta_out_if import fta_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fixed_timestep_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// fixed_timestep_accumulator_top
// Fixed-timestep accumulator with substep cap, 16.16 time, APB registers.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | beat
//  ---------+-----+-------------------+----------------------------------------
//  i_in     | in  | valid/ready       | mode, wall time, drag, seed, fail step
//  o_out    | out | valid/ready       | grant, flags, status, elapsed steps
//  apb      | in  | psel/penable      | step, speed, substep limit, threshold
//
//  Commands and skipped updates: accepted in the idle state, result given from
//  the final state. Updates: two multiplies, three add/subtract passes, then one
//  subtract per granted substep (max 255) and one to end the loop.
//  Reset: synchronous, active low; no clearing pass, ready the cycle after.
//  A held result does not stop the next beat being taken; a new result waits
//  in the final state until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_timestep_accumulator_top import fta_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    fta_in_if.sink                 i_in,
    fta_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    localparam int REQ_W = MUL_W - FRAC_BITS;
    localparam int ALU_W = (REQ_W > ACC_W) ? REQ_W : ACC_W;

    t_cfg             cfg;
    t_alu_op          alu_op;
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic [MUL_W-1:0] alu_res;
    logic             alu_carry;

    fta_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fta_alu #(
        .ALU_W (ALU_W)
    ) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    fta_core #(
        .FRAC_BITS (FRAC_BITS),
        .ALU_W     (ALU_W)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_alu_op    (alu_op),
        .o_alu_a     (alu_a),
        .o_alu_b     (alu_b),
        .i_alu_res   (alu_res),
        .i_alu_carry (alu_carry)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/fta_regs.sv =====
// ----------------------------------------------------------------------------
// fta_regs
// APB register bank: step length, speed, substep limit, suspend threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fta_regs import fta_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_length       <= STEP_RST;
            r_cfg.speed             <= SPEED_RST;
            r_cfg.max_substeps      <= MAX_RST;
            r_cfg.suspend_threshold <= THRESH_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_STEP:   r_cfg.step_length       <= pwdata[TIME_W-1:0];
                REG_SPEED:  r_cfg.speed             <= pwdata[SPEED_W-1:0];
                REG_MAX:    r_cfg.max_substeps      <= pwdata[SUB_W-1:0];
                REG_THRESH: r_cfg.suspend_threshold <= pwdata[TIME_W-1:0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            REG_STEP:   prdata = CFG_DW'(r_cfg.step_length);
            REG_SPEED:  prdata = CFG_DW'(r_cfg.speed);
            REG_MAX:    prdata = CFG_DW'(r_cfg.max_substeps);
            REG_THRESH: prdata = CFG_DW'(r_cfg.suspend_threshold);
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fta_alu.sv =====
// ----------------------------------------------------------------------------
// fta_alu
// Shared arithmetic unit: 32x24 multiply, or add / subtract with carry out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fta_alu import fta_pkg::*; #(
    parameter int ALU_W = 40
) (
    input  wire t_alu_op          i_op,
    input  wire logic [ALU_W-1:0] i_a,
    input  wire logic [ALU_W-1:0] i_b,
    output logic      [MUL_W-1:0] o_res,
    output logic                  o_carry
);

    logic [ALU_W:0]   sum;
    logic [MUL_W-1:0] prod;

    assign prod = MUL_W'(i_a[TIME_W-1:0]) * MUL_W'(i_b[SPEED_W-1:0]);

    // carry is the borrow on subtract: set when a < b
    always_comb begin
        sum     = '0;
        o_res   = '0;
        o_carry = 1'b0;
        case (i_op)
            ALU_ADD: begin
                sum     = {1'b0, i_a} + {1'b0, i_b};
                o_res   = MUL_W'(sum[ALU_W-1:0]);
                o_carry = sum[ALU_W];
            end
            ALU_SUB: begin
                sum     = {1'b0, i_a} - {1'b0, i_b};
                o_res   = MUL_W'(sum[ALU_W-1:0]);
                o_carry = sum[ALU_W];
            end
            ALU_MUL: begin
                o_res = prod;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fta_core.sv =====
// ----------------------------------------------------------------------------
// fta_core
// Sequencer: control events, time accumulation and the substep loop; time
// arithmetic goes through the shared unit one operation per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fta_core import fta_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int ALU_W     = 40
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    fta_in_if.sink                i_in,
    fta_out_if.source             o_out,
    output t_alu_op               o_alu_op,
    output logic      [ALU_W-1:0] o_alu_a,
    output logic      [ALU_W-1:0] o_alu_b,
    input  wire logic [MUL_W-1:0] i_alu_res,
    input  wire logic             i_alu_carry
);

    localparam int REQ_W = MUL_W - FRAC_BITS;

    // control state
    t_state               r_state, n_state;
    logic                 r_active, n_active;
    logic                 r_running, n_running;
    t_status              r_status, n_status;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic                 r_out_valid, n_out_valid;

    // per-item working registers
    logic [TIME_W-1:0] r_wall, n_wall;
    logic [SUB_W-1:0]  r_fail, n_fail;
    logic [REQ_W-1:0]  r_req, n_req;
    logic [ACC_W-1:0]  r_cap, n_cap;
    logic [ACC_W-1:0]  r_avail, n_avail;
    logic [ACC_W-1:0]  r_take, n_take;
    logic [SUB_W-1:0]  r_granted, n_granted;
    logic              r_behind, n_behind;
    logic              r_fault, n_fault;
    logic              r_ok, n_ok;
    t_out_item         r_out, n_out;

    t_mode in_mode;
    logic  regs_usable;

    assign in_mode     = t_mode'(i_in.data.mode);
    assign regs_usable = (i_cfg.step_length != '0) && (i_cfg.speed != '0)
                      && (i_cfg.max_substeps != '0) && (i_cfg.suspend_threshold != '0);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_running   <= 1'b0;
            r_status    <= ST_PAUSED;
            r_acc       <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_running   <= n_running;
            r_status    <= n_status;
            r_acc       <= n_acc;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_wall    <= n_wall;
        r_fail    <= n_fail;
        r_req     <= n_req;
        r_cap     <= n_cap;
        r_avail   <= n_avail;
        r_take    <= n_take;
        r_granted <= n_granted;
        r_behind  <= n_behind;
        r_fault   <= n_fault;
        r_ok      <= n_ok;
        r_out     <= n_out;
    end

    // next state, shared unit operands
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_running   = r_running;
        n_status    = r_status;
        n_acc       = r_acc;
        n_elapsed   = r_elapsed;
        n_out_valid = r_out_valid && !o_out.ready;
        n_wall      = r_wall;
        n_fail      = r_fail;
        n_req       = r_req;
        n_cap       = r_cap;
        n_avail     = r_avail;
        n_take      = r_take;
        n_granted   = r_granted;
        n_behind    = r_behind;
        n_fault     = r_fault;
        n_ok        = r_ok;
        n_out       = r_out;
        o_alu_op    = ALU_SUB;
        o_alu_a     = '0;
        o_alu_b     = '0;

        unique case (r_state)
            // take an event; commands finish here
            S_IDLE: begin
                if (i_in.valid) begin
                    n_wall    = i_in.data.wall_duration;
                    n_fail    = i_in.data.fail_at_step;
                    n_granted = '0;
                    n_behind  = 1'b0;
                    n_fault   = 1'b0;
                    n_ok      = 1'b0;
                    n_state   = S_FIN;
                    unique case (in_mode)
                        MODE_UPDATE: begin
                            if (r_active && r_running && !i_in.data.dragging
                                && (i_in.data.wall_duration != '0)) begin
                                if (i_in.data.wall_duration > i_cfg.suspend_threshold) begin
                                    n_status = ST_BEHIND;
                                    n_behind = 1'b1;
                                end else begin
                                    n_state = S_MREQ;
                                end
                            end
                        end
                        MODE_ENTER: begin
                            if (i_in.data.seed_valid && regs_usable) begin
                                n_acc     = '0;
                                n_elapsed = '0;
                                n_active  = 1'b1;
                                n_running = 1'b0;
                                n_status  = ST_PAUSED;
                                n_ok      = 1'b1;
                            end
                        end
                        MODE_LEAVE: begin
                            n_active  = 1'b0;
                            n_running = 1'b0;
                            n_acc     = '0;
                            n_status  = ST_PAUSED;
                        end
                        MODE_START: begin
                            if (r_active && (r_status != ST_FAULT)) begin
                                n_running = 1'b1;
                                n_status  = ST_RUNNING;
                                n_ok      = 1'b1;
                            end
                        end
                        MODE_PAUSE: begin
                            n_running = 1'b0;
                            if (r_active) begin
                                n_status = ST_PAUSED;
                            end
                        end
                        MODE_RESET: begin
                            if (r_active) begin
                                n_acc     = '0;
                                n_elapsed = '0;
                                n_running = 1'b0;
                                n_status  = ST_PAUSED;
                            end
                        end
                        MODE_RESEED: begin
                            if (r_active && i_in.data.seed_valid) begin
                                n_acc     = '0;
                                n_elapsed = '0;
                                n_status  = r_running ? ST_RUNNING : ST_PAUSED;
                                n_ok      = 1'b1;
                            end
                        end
                        MODE_DYNAMIC: begin
                            if (r_active) begin
                                n_acc     = '0;
                                n_running = 1'b0;
                                n_status  = ST_PAUSED;
                            end
                        end
                    endcase
                end
            end
            // requested sim time = wall * speed, fraction dropped
            S_MREQ: begin
                o_alu_op = ALU_MUL;
                o_alu_a  = ALU_W'(r_wall);
                o_alu_b  = ALU_W'(i_cfg.speed);
                n_req    = i_alu_res[FRAC_BITS +: REQ_W];
                n_state  = S_MCAP;
            end
            // capacity = step length * substep limit
            S_MCAP: begin
                o_alu_op = ALU_MUL;
                o_alu_a  = ALU_W'(i_cfg.step_length);
                o_alu_b  = ALU_W'(i_cfg.max_substeps);
                n_cap    = i_alu_res[ACC_W-1:0];
                n_state  = S_AVAIL;
            end
            // room left, floored at zero
            S_AVAIL: begin
                o_alu_op = ALU_SUB;
                o_alu_a  = ALU_W'(r_cap);
                o_alu_b  = ALU_W'(r_acc);
                n_avail  = i_alu_carry ? '0 : i_alu_res[ACC_W-1:0];
                n_state  = S_TAKE;
            end
            // clip request to the room; flag behind when clipped
            S_TAKE: begin
                o_alu_op = ALU_SUB;
                o_alu_a  = ALU_W'(r_avail);
                o_alu_b  = ALU_W'(r_req);
                n_behind = i_alu_carry;
                n_take   = i_alu_carry ? r_avail : ACC_W'(r_req);
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_alu_op = ALU_ADD;
                o_alu_a  = ALU_W'(r_acc);
                o_alu_b  = ALU_W'(r_take);
                n_acc    = i_alu_res[ACC_W-1:0];
                n_state  = S_LOOP;
            end
            // one substep per cycle
            S_LOOP: begin
                o_alu_op = ALU_SUB;
                o_alu_a  = ALU_W'(r_acc);
                o_alu_b  = ALU_W'(i_cfg.step_length);
                if ((r_granted == i_cfg.max_substeps) || i_alu_carry) begin
                    n_status = r_behind ? ST_BEHIND : ST_RUNNING;
                    n_state  = S_FIN;
                end else if ((r_granted + 8'd1) == r_fail) begin
                    n_running = 1'b0;
                    n_status  = ST_FAULT;
                    n_fault   = 1'b1;
                    n_state   = S_FIN;
                end else begin
                    n_acc     = i_alu_res[ACC_W-1:0];
                    n_elapsed = r_elapsed + 32'd1;
                    n_granted = r_granted + 8'd1;
                end
            end
            // hand the result to the output register once it is free
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid         = 1'b1;
                    n_out.granted_steps = r_granted;
                    n_out.state_changed = (r_granted != '0);
                    n_out.behind        = r_behind;
                    n_out.numeric_fault = r_fault;
                    n_out.status        = r_status;
                    n_out.command_ok    = r_ok;
                    n_out.elapsed_steps = r_elapsed;
                    n_state             = S_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fta_checker.sv =====
// ----------------------------------------------------------------------------
// fta_checker
// Port-level checks on the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fta_checker import fta_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_ready,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result beat changed while stalled");

    // one item at a time: no accept on the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while previous item in flight");

    // state_changed follows the grant count
    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.state_changed == (i_out_data.granted_steps != '0)))
        else $error("state_changed disagrees with granted_steps");

    // a fault leaves the numerical error status
    a_fault_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.numeric_fault) |-> (i_out_data.status == ST_FAULT))
        else $error("numeric fault without error status");

    // update flags and command acceptance never share a beat
    a_ok_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.command_ok) |->
            !(i_out_data.behind || i_out_data.numeric_fault || i_out_data.state_changed))
        else $error("command_ok set on an update result");

endmodule

bind fixed_timestep_accumulator_top fta_checker u_fta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire

// ===== tb/sv/fixed_timestep_accumulator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_timestep_accumulator_top_tb
// Self-checking bench for the fixed-timestep accumulator. Events go in over
// the input channel, an in-bench copy of the controller predicts each result
// beat, and every beat out is compared field by field. Registers are written
// over APB between phases; both channels idle and stall at random.
// ----------------------------------------------------------------------------

module fixed_timestep_accumulator_top_tb;
    import fta_pkg::*;

    localparam int FRAC         = 16;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_GAP   = 8;
    localparam int TAIL_CYCLES  = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    fta_in_if  in_if ();
    fta_out_if out_if ();

    fixed_timestep_accumulator_top #(.FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Register copy and controller state of the predictor
    logic [TIME_W-1:0]    cfg_step;
    logic [SPEED_W-1:0]   cfg_speed;
    logic [SUB_W-1:0]     cfg_max;
    logic [TIME_W-1:0]    cfg_thresh;
    logic                 ctl_active;
    logic                 ctl_running;
    t_status              ctl_status;
    logic [ACC_W-1:0]     ctl_acc;
    logic [ELAPSED_W-1:0] ctl_elapsed;

    t_out_item pending_results[$];

    // Run-wide flags and tallies
    bit          steady   = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned errors        = 0;
    int unsigned beats_sent    = 0;
    int unsigned beats_checked = 0;
    int unsigned granting_upd  = 0;
    int unsigned behind_seen   = 0;
    int unsigned faults_seen   = 0;
    int unsigned holds_done    = 0;
    int unsigned settings_used = 0;

    // Enter, reset and reseed all restart the simulated clock
    function automatic void clear_sim_time();
        ctl_acc     = '0;
        ctl_elapsed = '0;
    endfunction

    // Advance the controller by one event and return the result beat it gives
    function automatic t_out_item run_controller(t_in_item ev);
        t_out_item   res;
        logic [63:0] req;
        logic [63:0] cap;
        logic [63:0] avail;
        logic [63:0] take;
        int unsigned n;
        res = '0;
        n   = 0;
        case (t_mode'(ev.mode))
            MODE_UPDATE: begin
                if (ctl_active && ctl_running && !ev.dragging && ev.wall_duration != 0) begin
                    if (ev.wall_duration > cfg_thresh) begin
                        ctl_status = ST_BEHIND;
                        res.behind = 1'b1;
                    end else begin
                        req   = (64'(ev.wall_duration) * 64'(cfg_speed)) >> FRAC;
                        cap   = 64'(cfg_step) * 64'(cfg_max);
                        avail = (cap > 64'(ctl_acc)) ? cap - 64'(ctl_acc) : 64'd0;
                        take  = (req < avail) ? req : avail;
                        res.behind = (req > avail);
                        ctl_acc = ACC_W'(64'(ctl_acc) + take);
                        // substep loop; stops early on an integration fault
                        while (n < cfg_max && 64'(ctl_acc) >= 64'(cfg_step)
                               && !res.numeric_fault) begin
                            if (n + 1 == ev.fail_at_step) begin
                                ctl_running       = 1'b0;
                                ctl_status        = ST_FAULT;
                                res.numeric_fault = 1'b1;
                            end else begin
                                ctl_acc     = ctl_acc - ACC_W'(cfg_step);
                                ctl_elapsed = ctl_elapsed + 1'b1;
                                n++;
                            end
                        end
                        if (!res.numeric_fault)
                            ctl_status = res.behind ? ST_BEHIND : ST_RUNNING;
                    end
                end
            end
            MODE_ENTER: begin
                if (ev.seed_valid && cfg_step != 0 && cfg_speed != 0 && cfg_max != 0
                    && cfg_thresh != 0) begin
                    clear_sim_time();
                    ctl_active     = 1'b1;
                    ctl_running    = 1'b0;
                    ctl_status     = ST_PAUSED;
                    res.command_ok = 1'b1;
                end
            end
            MODE_LEAVE: begin
                ctl_active  = 1'b0;
                ctl_running = 1'b0;
                ctl_acc     = '0;
                ctl_status  = ST_PAUSED;
            end
            MODE_START: begin
                if (ctl_active && ctl_status != ST_FAULT) begin
                    ctl_running    = 1'b1;
                    ctl_status     = ST_RUNNING;
                    res.command_ok = 1'b1;
                end
            end
            MODE_PAUSE: begin
                ctl_running = 1'b0;
                if (ctl_active)
                    ctl_status = ST_PAUSED;
            end
            MODE_RESET: begin
                if (ctl_active) begin
                    clear_sim_time();
                    ctl_running = 1'b0;
                    ctl_status  = ST_PAUSED;
                end
            end
            MODE_RESEED: begin
                if (ctl_active && ev.seed_valid) begin
                    clear_sim_time();
                    ctl_status     = ctl_running ? ST_RUNNING : ST_PAUSED;
                    res.command_ok = 1'b1;
                end
            end
            MODE_DYNAMIC: begin
                if (ctl_active) begin
                    ctl_acc     = '0;
                    ctl_running = 1'b0;
                    ctl_status  = ST_PAUSED;
                end
            end
        endcase
        res.granted_steps = SUB_W'(n);
        res.state_changed = (n != 0);
        res.status        = ctl_status;
        res.elapsed_steps = ctl_elapsed;
        return res;
    endfunction

    // Stall length: mostly short, now and then long
    function automatic int unsigned stall_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned sender_gap();
        if (steady || $urandom_range(0, 99) < 55)
            return 0;
        return stall_len();
    endfunction

    function automatic t_in_item make_event(t_mode m, logic [TIME_W-1:0] wall, bit drag,
                                            bit seed, logic [SUB_W-1:0] fail_at);
        t_in_item ev;
        ev.mode          = m;
        ev.wall_duration = wall;
        ev.dragging      = drag;
        ev.seed_valid    = seed;
        ev.fail_at_step  = fail_at;
        return ev;
    endfunction

    // Random event, steered by the predicted state so most sequences get to updates.
    // With no_leave set the block is kept active (zero-register phases).
    function automatic t_in_item random_event(bit no_leave);
        t_in_item ev;
        t_mode    m;
        int unsigned r;
        ev.dragging   = ($urandom_range(0, 9) == 0);
        ev.seed_valid = ($urandom_range(0, 7) != 0);
        r = $urandom_range(0, 99);
        if (r < 75)
            ev.fail_at_step = '0;
        else if (r < 90)
            ev.fail_at_step = SUB_W'($urandom_range(1, int'(cfg_max) + 1));
        else
            ev.fail_at_step = SUB_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8)
            ev.wall_duration = '0;
        else if (r < 20)
            ev.wall_duration = $urandom;
        else if (r < 55 && cfg_thresh != 0)
            ev.wall_duration = $urandom_range(1, cfg_thresh);
        else
            ev.wall_duration = $urandom >> $urandom_range(0, 31);
        r = $urandom_range(0, 99);
        m = t_mode'(3'($urandom_range(0, 7)));
        if (!ctl_active) begin
            if (r < 75)
                m = MODE_ENTER;
        end else if (ctl_status == ST_FAULT) begin
            if (r < 40)
                m = no_leave ? MODE_RESEED : MODE_ENTER;
        end else if (!ctl_running) begin
            if (r < 70)
                m = MODE_START;
        end else if (r < 75) begin
            m = MODE_UPDATE;
        end
        if (no_leave && m == MODE_LEAVE)
            m = MODE_UPDATE;
        ev.mode = m;
        return ev;
    endfunction

    // Offer one event beat and wait for it to be taken
    task automatic send_event(t_in_item ev);
        int unsigned gap;
        gap = sender_gap();
        repeat (gap) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= ev;
        @(posedge i_clk);
        while (!(in_if.valid && in_if.ready))
            @(posedge i_clk);
        pending_results.push_back(run_controller(ev));
        beats_sent++;
    endtask

    // Let every expected result come back (bounded wait), then idle for SETTLE_GAP
    task automatic settle();
        int unsigned waited;
        waited = 0;
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(t_reg_idx idx, logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STEP:   cfg_step   = value[TIME_W-1:0];
            REG_SPEED:  cfg_speed  = value[SPEED_W-1:0];
            REG_MAX:    cfg_max    = value[SUB_W-1:0];
            REG_THRESH: cfg_thresh = value[TIME_W-1:0];
        endcase
    endtask

    task automatic set_config(logic [31:0] step, logic [31:0] spd, logic [31:0] max_sub,
                              logic [31:0] thresh);
        settle();
        write_reg(REG_STEP, step);
        write_reg(REG_SPEED, spd);
        write_reg(REG_MAX, max_sub);
        write_reg(REG_THRESH, thresh);
        settings_used++;
    endtask

    task automatic random_events(int unsigned count, bit no_leave);
        repeat (count) send_event(random_event(no_leave));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Everything sent to an inactive block: updates ignored, start refused
    task automatic test_inactive_commands();
        send_event(make_event(MODE_UPDATE, 32'd100, 1'b0, 1'b0, 8'd0));
        send_event(make_event(MODE_START, 32'd0, 1'b0, 1'b1, 8'd0));
        send_event(make_event(MODE_PAUSE, 32'd0, 1'b0, 1'b0, 8'd0));
        send_event(make_event(MODE_RESET, 32'd0, 1'b0, 1'b0, 8'd0));
        send_event(make_event(MODE_RESEED, 32'd0, 1'b0, 1'b1, 8'd0));
        send_event(make_event(MODE_DYNAMIC, 32'd0, 1'b0, 1'b0, 8'd0));
        send_event(make_event(MODE_LEAVE, 32'd0, 1'b0, 1'b0, 8'd0));
        settle();
    endtask

    // Normal life cycle at reset settings, with each update special case
    task automatic test_control_sequence();
        send_event(make_event(MODE_ENTER, 32'd0, 1'b0, 1'b0, 8'd0));       // bad seed
        send_event(make_event(MODE_ENTER, 32'd0, 1'b0, 1'b1, 8'd0));
        send_event(make_event(MODE_UPDATE, 32'd5000, 1'b0, 1'b0, 8'd0));  // not running
        send_event(make_event(MODE_START, 32'd0, 1'b0, 1'b0, 8'd0));
        send_event(make_event(MODE_UPDATE, 32'd1092, 1'b0, 1'b0, 8'd0));  // one step
        send_event(make_event(MODE_UPDATE, 32'd5000, 1'b1, 1'b0, 8'd0));  // dragging
        send_event(make_event(MODE_UPDATE, 32'd0, 1'b0, 1'b0, 8'd0));     // zero wall
        send_event(make_event(MODE_UPDATE, 32'd16385, 1'b0, 1'b0, 8'd0)); // over threshold
        send_event(make_event(MODE_UPDATE, 32'd16384, 1'b0, 1'b0, 8'd0)); // capacity cap
        send_event(make_event(MODE_UPDATE, 32'd3000, 1'b0, 1'b0, 8'd2));  // fault
        send_event(make_event(MODE_START, 32'd0, 1'b0, 1'b0, 8'd0));      // refused
        send_event(make_event(MODE_RESEED, 32'd0, 1'b0, 1'b0, 8'd0));     // bad seed
        send_event(make_event(MODE_RESEED, 32'd0, 1'b0, 1'b1, 8'd0));
        send_event(make_event(MODE_START, 32'd0, 1'b0, 1'b0, 8'd0));
        send_event(make_event(MODE_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'hFF));
        send_event(make_event(MODE_PAUSE, 32'd0, 1'b0, 1'b0, 8'd0));
        send_event(make_event(MODE_START, 32'd0, 1'b0, 1'b0, 8'd0));
        send_event(make_event(MODE_DYNAMIC, 32'd0, 1'b0, 1'b0, 8'd0));
        settle();
    endtask

    // Sink holds off for a long stretch while events keep coming
    task automatic test_output_backpressure();
        send_event(make_event(MODE_ENTER, 32'd0, 1'b0, 1'b1, 8'd0));
        send_event(make_event(MODE_START, 32'd0, 1'b0, 1'b0, 8'd0));
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (12)
            send_event(make_event(MODE_UPDATE, $urandom_range(1, 4000), 1'b0, 1'b0, 8'd0));
        steady = 1'b0;
        settle();
    endtask

    // Random traffic over a range of register settings, extremes included
    task automatic test_random_settings();
        set_config(STEP_RST, SPEED_RST, MAX_RST, THRESH_RST);
        random_events(150, 1'b0);
        set_config(32'd1, 32'hFF_FFFF, 32'd255, 32'hFFFF_FFFF);
        random_events(60, 1'b0);
        set_config(32'hFFFF_FFFF, 32'hFF_FFFF, 32'd255, 32'hFFFF_FFFF);
        random_events(60, 1'b0);
        repeat (4) begin
            set_config($urandom_range(1, 4000), $urandom_range(1, 3 * 65536),
                       $urandom_range(1, 16), $urandom_range(1, 200000));
            random_events(80, 1'b0);
        end
        set_config(32'd500, 32'd1, 32'd1, 32'hFFFF_FFFF);
        steady = 1'b1;                     // stretch with no idling on either side
        random_events(60, 1'b0);
        steady = 1'b0;
        set_config(32'd1092, 32'd65536, 32'd8, 32'd1);
        random_events(40, 1'b0);
    endtask

    // Each register in turn set to zero once the block is active
    task automatic test_zero_registers();
        t_reg_idx idx;
        for (int k = 0; k < 4; k++) begin
            idx = t_reg_idx'(k);
            set_config(32'd800, 32'd65536, 32'd6, 32'd20000);
            send_event(make_event(MODE_ENTER, 32'd0, 1'b0, 1'b1, 8'd0));
            send_event(make_event(MODE_START, 32'd0, 1'b0, 1'b0, 8'd0));
            settle();
            write_reg(idx, 32'd0);
            random_events(25, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random ready, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                stall_left = HOLD_CYCLES - 1;
                hold_req   = 1'b0;
                holds_done++;
                out_if.ready <= 1'b0;
            end else if (steady || $urandom_range(0, 99) < 70) begin
                out_if.ready <= 1'b1;
            end else begin
                stall_left = stall_len() - 1;
                out_if.ready <= 1'b0;
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out_item exp_r;
        t_out_item got_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_r = out_if.data;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected (status %0d)", got_r.status);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                beats_checked++;
                if (exp_r.state_changed) granting_upd++;
                if (exp_r.behind)        behind_seen++;
                if (exp_r.numeric_fault) faults_seen++;
                if (got_r.granted_steps !== exp_r.granted_steps) begin
                    $error("granted_steps: expected %0d, got %0d",
                           exp_r.granted_steps, got_r.granted_steps);
                    errors++;
                end
                if (got_r.state_changed !== exp_r.state_changed) begin
                    $error("state_changed: expected %0d, got %0d",
                           exp_r.state_changed, got_r.state_changed);
                    errors++;
                end
                if (got_r.behind !== exp_r.behind) begin
                    $error("behind: expected %0d, got %0d", exp_r.behind, got_r.behind);
                    errors++;
                end
                if (got_r.numeric_fault !== exp_r.numeric_fault) begin
                    $error("numeric_fault: expected %0d, got %0d",
                           exp_r.numeric_fault, got_r.numeric_fault);
                    errors++;
                end
                if (got_r.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
                    errors++;
                end
                if (got_r.command_ok !== exp_r.command_ok) begin
                    $error("command_ok: expected %0d, got %0d",
                           exp_r.command_ok, got_r.command_ok);
                    errors++;
                end
                if (got_r.elapsed_steps !== exp_r.elapsed_steps) begin
                    $error("elapsed_steps: expected %0d, got %0d",
                           exp_r.elapsed_steps, got_r.elapsed_steps);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int unsigned waited;
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        cfg_step    = STEP_RST;
        cfg_speed   = SPEED_RST;
        cfg_max     = MAX_RST;
        cfg_thresh  = THRESH_RST;
        ctl_active  = 1'b0;
        ctl_running = 1'b0;
        ctl_status  = ST_PAUSED;
        clear_sim_time();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_inactive_commands();
        test_control_sequence();
        test_output_backpressure();
        test_random_settings();
        test_zero_registers();

        // wait out the tail, bounded
        in_if.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_results.size());
            errors++;
        end

        $display("Run covered %0d event beats and %0d result beats over %0d register settings.",
                 beats_sent, beats_checked, settings_used);
        $display("Updates granting steps: %0d, behind: %0d, numeric faults: %0d, long holds: %0d",
                 granting_upd, behind_seen, faults_seen, holds_done);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
